@@ sv/msiq_pkg.sv @@
// Shared types and constants for the sorted insertion queue.
package msiq_pkg;

    localparam int unsigned DAY_W = 22;
    localparam int unsigned MIN_W = 11;
    localparam int unsigned URG_W = 14;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned TAG_W = 16;
    localparam int unsigned CODE_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] RESP_INSERTED = 2'd0;
    localparam logic [CODE_W-1:0] RESP_FULL     = 2'd1;
    localparam logic [CODE_W-1:0] RESP_ENTRY    = 2'd2;
    localparam logic [CODE_W-1:0] RESP_EMPTY    = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DATE_DESC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_DESC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_DESC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNTIMED_LEAD = 2'd3;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MIN_W-1:0]  minute;
        logic              untimed;
        logic [URG_W-1:0]  urgency;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic date_desc;
        logic time_desc;
        logic prio_desc;
        logic untimed_lead;
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;   // shift and write the incoming entry
        logic pop;      // shift the whole row one place toward the head
        logic clear;    // drop all entries
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } dp_stat_t;

endpackage

@@ sv/msiq_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
interface msiq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [msiq_pkg::DAY_W-1:0]       day_number;
    logic [msiq_pkg::MIN_W-1:0]       minute_of_day;
    logic                             is_untimed;
    logic [msiq_pkg::URG_W-1:0]       urgency;
    logic [msiq_pkg::KIND_W-1:0]      entry_kind;
    logic [msiq_pkg::TAG_W-1:0]       payload_tag;
    modport source (output valid, req_type, day_number, minute_of_day, is_untimed,
                    urgency, entry_kind, payload_tag, input ready);
    modport sink (input valid, req_type, day_number, minute_of_day, is_untimed,
                  urgency, entry_kind, payload_tag, output ready);
endinterface

interface msiq_resp_if;
    logic                             valid;
    logic                             ready;
    logic [msiq_pkg::CODE_W-1:0]      resp_code;
    logic [msiq_pkg::DAY_W-1:0]       out_day;
    logic [msiq_pkg::MIN_W-1:0]       out_minute;
    logic                             out_untimed;
    logic [msiq_pkg::URG_W-1:0]       out_urgency;
    logic [msiq_pkg::KIND_W-1:0]      out_kind;
    logic [msiq_pkg::TAG_W-1:0]       out_tag;
    logic                             last;
    modport source (output valid, resp_code, out_day, out_minute, out_untimed,
                    out_urgency, out_kind, out_tag, last, input ready);
    modport sink (input valid, resp_code, out_day, out_minute, out_untimed,
                  out_urgency, out_kind, out_tag, last, output ready);
endinterface

interface msiq_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/msiq_datapath.sv @@
// Cell row that holds the sorted entries, with compare and shift logic.
module msiq_datapath #(
    parameter int unsigned DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msiq_pkg::dp_cmd_t  cmd,
    input  msiq_pkg::entry_t   new_entry,
    input  msiq_pkg::mode_t    mode,
    output msiq_pkg::dp_stat_t stat,
    output msiq_pkg::entry_t   head
);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    msiq_pkg::entry_t slot_reg [DEPTH];
    msiq_pkg::entry_t slot_next [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DEPTH-1:0] valid_slot;
    logic [DEPTH-1:0] ahead;    // new entry ranks ahead of slot i
    logic [DEPTH-1:0] take;     // slot i receives the new entry or its left neighbor

    function automatic logic goes_before(msiq_pkg::entry_t a, msiq_pkg::entry_t s,
                                         msiq_pkg::mode_t md);
        logic r;
        if (a.day != s.day)
            r = md.date_desc ? (a.day > s.day) : (a.day < s.day);
        else if (a.untimed != s.untimed)
            r = md.untimed_lead ? a.untimed : !a.untimed;
        else if (!a.untimed && a.minute != s.minute)
            r = md.time_desc ? (a.minute > s.minute) : (a.minute < s.minute);
        else if (a.urgency != s.urgency)
            r = md.prio_desc ? (a.urgency > s.urgency) : (a.urgency < s.urgency);
        else
            r = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_slot[i] = (CNT_W'(i) < count_reg);
            ahead[i] = valid_slot[i] && goes_before(new_entry, slot_reg[i], mode);
        end
        // Slots from the first "ahead" position, or the first empty one, move down.
        take[0] = ahead[0] || !valid_slot[0];
        for (int i = 1; i < DEPTH; i++)
            take[i] = take[i-1] || ahead[i] || !valid_slot[i];
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
            slot_next[i] = slot_reg[i];
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i == 0)
                    slot_next[i] = take[0] ? new_entry : slot_reg[0];
                else if (take[i])
                    slot_next[i] = take[i-1] ? slot_reg[i-1] : new_entry;
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            for (int i = 0; i < DEPTH - 1; i++)
                slot_next[i] = slot_reg[i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_W'(DEPTH));
    assign stat.one_left = (count_reg == CNT_W'(1));
    assign head          = slot_reg[0];
endmodule

@@ sv/msiq_ctrl.sv @@
// Controller state machine: accepts requests and sequences results.
module msiq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_type,
    output logic                        req_ready,
    input  logic                        resp_ready,
    output logic                        resp_valid,
    output logic [msiq_pkg::CODE_W-1:0] resp_code,
    output logic                        resp_from_head,
    output logic                        last,
    input  msiq_pkg::dp_stat_t          stat,
    output msiq_pkg::dp_cmd_t           cmd
);
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_REPLY = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [msiq_pkg::CODE_W-1:0] code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        resp_valid = 1'b0;
        resp_from_head = 1'b0;
        last       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == msiq_pkg::REQ_INSERT)
                    begin
                        if (stat.full)
                            code_next = msiq_pkg::RESP_FULL;
                        else
                        begin
                            code_next  = msiq_pkg::RESP_INSERTED;
                            cmd.insert = 1'b1;
                        end
                        state_next = ST_REPLY;
                    end
                    else if (stat.empty)
                    begin
                        code_next  = msiq_pkg::RESP_EMPTY;
                        state_next = ST_REPLY;
                    end
                    else
                        state_next = ST_DRAIN;
                end
            end
            ST_REPLY:
            begin
                resp_valid = 1'b1;
                if (resp_ready)
                    state_next = ST_IDLE;
            end
            ST_DRAIN:
            begin
                resp_valid     = 1'b1;
                resp_from_head = 1'b1;
                last           = stat.one_left;
                if (resp_ready)
                begin
                    cmd.pop = 1'b1;
                    if (stat.one_left)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign resp_code = resp_from_head ? msiq_pkg::RESP_ENTRY : code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            code_reg  <= msiq_pkg::RESP_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end
endmodule

@@ sv/multikey_sorted_insert_queue.sv @@
// Top level of the multi-key sorted insertion queue.
//
// Requests arrive on the req channel (valid/ready). An insert places the
// entry into a row of cells kept in sorted order by date, then time or
// untimed mark, then urgency; equal keys keep their arrival order. The
// cfg channel writes the four one-bit ordering modes and is always ready.
// In the transfer cycle of an insert the row shifts and the entry is
// written; the result is offered in the next cycle. If the row already
// holds DEPTH entries the item is dropped with a full code. A drain
// offers one stored entry per cycle from the head of the row while the
// receiver is ready, with last on the final one; a drain of an empty
// queue yields a single empty code. A new request is taken only after
// every result of the previous one has been transferred. When the
// receiver stalls, the current result holds on the resp channel and the
// row does not move. Reset empties the queue at once and clears all modes.
module multikey_sorted_insert_queue #(
    parameter int unsigned DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    msiq_req_if.sink      req,
    msiq_resp_if.source   resp,
    msiq_cfg_if.sink      cfg
);
    msiq_pkg::mode_t    mode_reg, mode_next;
    msiq_pkg::dp_cmd_t  cmd;
    msiq_pkg::dp_stat_t stat;
    msiq_pkg::entry_t   new_entry;
    msiq_pkg::entry_t   head;
    logic               from_head;

    // Configuration writes; only bit 0 of the data matters, other indexes are ignored.
    assign cfg.ready = 1'b1;
    always_comb
    begin
        mode_next = mode_reg;
        if (cfg.valid && cfg.index[7:msiq_pkg::CFG_IDX_W] == '0)
        begin
            case (cfg.index[msiq_pkg::CFG_IDX_W-1:0])
                msiq_pkg::CFG_DATE_DESC:    mode_next.date_desc = cfg.data[0];
                msiq_pkg::CFG_TIME_DESC:    mode_next.time_desc = cfg.data[0];
                msiq_pkg::CFG_PRIO_DESC:    mode_next.prio_desc = cfg.data[0];
                msiq_pkg::CFG_UNTIMED_LEAD: mode_next.untimed_lead = cfg.data[0];
                default:                    mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= '0;
        else
            mode_reg <= mode_next;
    end

    // An untimed entry stores its minute as zero.
    always_comb
    begin
        new_entry.day     = req.day_number;
        new_entry.minute  = req.is_untimed ? '0 : req.minute_of_day;
        new_entry.untimed = req.is_untimed;
        new_entry.urgency = req.urgency;
        new_entry.kind    = req.entry_kind;
        new_entry.tag     = req.payload_tag;
    end

    msiq_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req.valid),
        .req_type       (req.req_type),
        .req_ready      (req.ready),
        .resp_ready     (resp.ready),
        .resp_valid     (resp.valid),
        .resp_code      (resp.resp_code),
        .resp_from_head (from_head),
        .last           (resp.last),
        .stat           (stat),
        .cmd            (cmd)
    );

    msiq_datapath #(.DEPTH(DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_entry (new_entry),
        .mode      (mode_reg),
        .stat      (stat),
        .head      (head)
    );

    // Status results carry zeros in every entry field.
    assign resp.out_day     = from_head ? head.day     : '0;
    assign resp.out_minute  = from_head ? head.minute  : '0;
    assign resp.out_untimed = from_head ? head.untimed : 1'b0;
    assign resp.out_urgency = from_head ? head.urgency : '0;
    assign resp.out_kind    = from_head ? head.kind    : '0;
    assign resp.out_tag     = from_head ? head.tag     : '0;
endmodule

@@ sv/msiq_checker.sv @@
// Port-level checker for the sorted insertion queue, bound to the top level.
module msiq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        resp_valid,
    input logic                        resp_ready,
    input logic [msiq_pkg::CODE_W-1:0] resp_code,
    input logic                        last
);
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp_code))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> !req_ready)
        else $error("request taken while a result is pending");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_code != msiq_pkg::RESP_ENTRY |-> last)
        else $error("status result without last");

    a_reply_next: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> resp_valid)
        else $error("no result after request");
endmodule

bind multikey_sorted_insert_queue msiq_checker u_msiq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .resp_valid (resp.valid),
    .resp_ready (resp.ready),
    .resp_code  (resp.resp_code),
    .last       (resp.last)
);
